[rtl/itd_pkg.sv]
// shared constants for the signed integer to decimal text core
package itd_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // decimal digits needed for 2^(bits-1), the largest magnitude
    function automatic int digit_count(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

[rtl/itd_front.sv]
// input side: takes a word, splits it into sign flag and magnitude
module itd_front import itd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic                  push_neg,
    output logic [VALUE_BITS-1:0] push_mag
);

    // most negative value negates to itself, which is the right unsigned magnitude
    assign push_neg   = s_value[VALUE_BITS-1];
    assign push_mag   = push_neg ? (~s_value + VALUE_BITS'(1)) : s_value;
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

[rtl/itd_queue.sv]
// two-entry queue between the input side and the converter
module itd_queue import itd_pkg::*; #(
    parameter int WIDTH = VALUE_BITS_DEF + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry0_reg, entry1_reg;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = rd_ptr_reg ? entry1_reg : entry0_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !wr_ptr_reg) begin
            entry0_reg <= in_data;
        end
        if (push && wr_ptr_reg) begin
            entry1_reg <= in_data;
        end
    end

endmodule

[rtl/itd_back.sv]
// converter: shift-and-add-3 binary to bcd, then emits characters msd first
module itd_back import itd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic                  q_neg,
    input  logic [VALUE_BITS-1:0] q_mag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_text_char,
    output logic                  m_last
);

    localparam int NDIG  = digit_count(VALUE_BITS);
    localparam int BCD_W = 4 * NDIG;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_SIGN,
        S_DIGIT
    } state_t;

    state_t                 state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;

    logic [BCD_W-1:0]       bcd_adj;
    logic [IDX_W-1:0]       lead_idx;
    logic [3:0]             cur_digit;
    logic                   out_free;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ?
                                (bcd_reg[4*d +: 4] + 4'd3) : bcd_reg[4*d +: 4];
        end
    end

    // highest nonzero digit, or the units digit for zero
    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (bcd_reg[4*d +: 4] != 4'd0) begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = bcd_reg[4*idx_reg +: 4];
    assign out_free  = !out_valid_reg || m_ready;
    assign q_ready   = (state_reg == S_IDLE);

    assign m_valid     = out_valid_reg;
    assign m_text_char = out_char_reg;
    assign m_last      = out_last_reg;

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    neg_next   = q_neg;
                    mag_next   = q_mag;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_LEAD;
                end
            end
            S_LEAD: begin
                idx_next   = lead_idx;
                state_next = neg_reg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {2'b00, cur_digit};
                    out_last_next  = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/signed_int_to_decimal_ascii_core.sv]
// signed integer to decimal ascii text, one character per output word
// an accepted value goes through the conversion and leading-digit states, then the
//   sign or digit state puts its first character into the output register
// the one-bit-per-cycle shift-and-add-3 converter takes a value only when idle
// a two-entry queue lets the input side take words while the converter works
// reset: synchronous active-low aresetn empties the queue and output register
module signed_int_to_decimal_ascii_core import itd_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_text_char,
    output logic                  m_last
);

    logic                  push_valid, push_ready, push_neg;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  q_valid, q_ready;
    logic [VALUE_BITS:0]   q_data;

    itd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_neg   (push_neg),
        .push_mag   (push_mag)
    );

    itd_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_neg, push_mag}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    itd_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_neg       (q_data[VALUE_BITS]),
        .q_mag       (q_data[VALUE_BITS-1:0]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

endmodule
